/* rtl/mnb_pkg.sv */
// ----------------------------------------------------------------------------
// mnb_pkg: shared types and constants for the meter needle ballistics block
// Transaction payloads, configuration register map, sequencer states.
// ----------------------------------------------------------------------------
package mnb_pkg;

	localparam int VALUE_WIDTH_DEF = 16;   // default width of target/display state
	localparam int FIELD_W         = 16;   // width of value, angle and range fields
	localparam int SHIFT_W         = 5;    // attack/decay shift width
	localparam int CFG_IDX_W       = 3;    // configuration register index width
	localparam int DIVISOR_W       = 16;   // divisor width of the shared divider
	localparam int PCT_W           = 24;   // magnitude width kept for the percentage
	localparam int PCT_SCALE       = 100;  // percent scale

	// register reset values
	localparam logic signed [FIELD_W-1:0] MIN_RST       = 16'sd0;
	localparam logic signed [FIELD_W-1:0] MAX_RST       = 16'sd100;
	localparam logic signed [FIELD_W-1:0] ANGLE_BEG_RST = 16'sd0;
	localparam logic signed [FIELD_W-1:0] ANGLE_END_RST = 16'sd180;

	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_VALUE    = 3'd0,
		CFG_MAX_VALUE    = 3'd1,
		CFG_ATTACK_SHIFT = 3'd2,
		CFG_DECAY_SHIFT  = 3'd3,
		CFG_ANGLE_START  = 3'd4,
		CFG_ANGLE_END    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] min_value;
		logic signed [FIELD_W-1:0] max_value;
		logic        [SHIFT_W-1:0] attack_shift;
		logic        [SHIFT_W-1:0] decay_shift;
		logic signed [FIELD_W-1:0] angle_start;
		logic signed [FIELD_W-1:0] angle_end;
	} cfg_t;

	typedef struct packed {
		op_t                       op;
		logic signed [FIELD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] shown_value;
		logic signed [FIELD_W-1:0] needle_angle;
		logic                      settled;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,   // waiting for a transaction
		ST_PCT  = 2'd1,   // divider forms the percentage
		ST_MUL  = 2'd2,   // angle span times percentage, divider restarted by 100
		ST_ANG  = 2'd3    // divider forms the angle offset
	} st_t;

endpackage

/* rtl/mnb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mnb_cfg_regs: configuration register file
// Plain write port; indexes past the map are dropped.
// ----------------------------------------------------------------------------
module mnb_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [mnb_pkg::CFG_IDX_W-1:0]      index,
	input  logic [mnb_pkg::FIELD_W-1:0]        wdata,
	output mnb_pkg::cfg_t                      cfg
);

	mnb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_value    <= mnb_pkg::MIN_RST;
			cfg_q.max_value    <= mnb_pkg::MAX_RST;
			cfg_q.attack_shift <= '0;
			cfg_q.decay_shift  <= '0;
			cfg_q.angle_start  <= mnb_pkg::ANGLE_BEG_RST;
			cfg_q.angle_end    <= mnb_pkg::ANGLE_END_RST;
		end else if (we) begin
			unique case (mnb_pkg::cfg_idx_t'(index))
				mnb_pkg::CFG_MIN_VALUE:    cfg_q.min_value    <= wdata;
				mnb_pkg::CFG_MAX_VALUE:    cfg_q.max_value    <= wdata;
				mnb_pkg::CFG_ATTACK_SHIFT: cfg_q.attack_shift <= wdata[mnb_pkg::SHIFT_W-1:0];
				mnb_pkg::CFG_DECAY_SHIFT:  cfg_q.decay_shift  <= wdata[mnb_pkg::SHIFT_W-1:0];
				mnb_pkg::CFG_ANGLE_START:  cfg_q.angle_start  <= wdata;
				mnb_pkg::CFG_ANGLE_END:    cfg_q.angle_end    <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/mnb_divider.sv */
// ----------------------------------------------------------------------------
// mnb_divider: shared unsigned restoring divider
// One quotient bit per cycle, one-cycle done pulse after the last.
// ----------------------------------------------------------------------------
module mnb_divider #(
	parameter int DW = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [DW-1:0]                     dividend,
	input  logic [mnb_pkg::DIVISOR_W-1:0]     divisor,
	output logic                              done,
	output logic [DW-1:0]                     quotient
);

	localparam int CW = $clog2(DW + 1);
	localparam int RW = mnb_pkg::DIVISOR_W;

	logic [DW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/meter_needle_ballistics.sv */
// ----------------------------------------------------------------------------
// meter_needle_ballistics: VU meter attack/decay needle ballistics
// Keeps a target and a displayed value, steps the display toward the target
// on each tick and reports the needle angle of the value drawn.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+-----------
//  item     | item_valid, item_ready, item          | in
//  result   | result_valid, result_ready, result    | out
//  config   | cfg_we, cfg_index, cfg_data           | in
//
// A set transaction, like a tick while max_value equals min_value, loads
// its result at acceptance. Any other tick runs the shared restoring
// divider twice, once for the percentage and once for the division by
// 100, one quotient bit per cycle.
// item_ready is high only in the idle state with the result register free
// or being emptied, so one result waits at most. No clearing pass: reset
// puts target, display and the register file at their reset values at once.
//
module meter_needle_ballistics #(
	parameter int VALUE_WIDTH = mnb_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  mnb_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output mnb_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [mnb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mnb_pkg::FIELD_W-1:0]    cfg_data
);

	localparam int VW   = VALUE_WIDTH;
	localparam int FW   = mnb_pkg::FIELD_W;
	localparam int SW   = ((VW > FW) ? VW : FW) + 1;        // common signed width
	localparam int DIVW = (SW + 7 > 40) ? SW + 7 : 40;      // divider word
	localparam int AW   = DIVW + 2;                         // angle sum width
	localparam int PW   = mnb_pkg::PCT_W;

	localparam logic signed [AW-1:0] ANG_HI = AW'(2 ** (FW - 1) - 1);
	localparam logic signed [AW-1:0] ANG_LO = AW'(-(2 ** (FW - 1)));

	mnb_pkg::cfg_t    cfg;
	mnb_pkg::st_t     state_q, state_d;
	mnb_pkg::result_t res_q;
	logic             res_valid_q;

	logic signed [VW-1:0] target_q;
	logic signed [VW-1:0] display_q;

	// sequencer controls
	logic accept;
	logic is_tick;
	logic span_empty;
	logic div_start;
	logic div_done;
	logic quick_done;     // result ready in the accept cycle
	logic finish;         // angle done, result goes out
	logic load_pct;
	logic [DIVW-1:0]          div_dividend;
	logic [DIVW-1:0]          div_quotient;
	logic [mnb_pkg::DIVISOR_W-1:0] div_divisor;

	mnb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	mnb_divider #(.DW(DIVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign accept  = item_valid && item_ready;
	assign is_tick = (item.op == mnb_pkg::OP_TICK);

	// ---------------- set path: clamp and optional jump ----------------
	logic signed [SW-1:0] cur_x, val_x, min_x, max_x;
	logic                 below, above, jump;
	logic signed [FW-1:0] clamp_v;
	logic signed [VW-1:0] tgt_new;

	assign cur_x = SW'(display_q);
	assign val_x = SW'(item.value);
	assign min_x = SW'(cfg.min_value);
	assign max_x = SW'(cfg.max_value);

	// below-min is checked first, so an inverted range stores min_value for a value below it, else max_value
	assign below   = val_x < min_x;
	assign above   = val_x > max_x;
	assign clamp_v = below ? cfg.min_value : (above ? cfg.max_value : item.value);
	assign tgt_new = VW'(clamp_v);
	// only an in-range set may jump the needle
	assign jump    = !below && !above &&
	                 (((cur_x < val_x) && (cfg.attack_shift == '0)) ||
	                  ((cur_x > val_x) && (cfg.decay_shift == '0)));

	// ---------------- tick path: step toward the target ----------------
	logic signed [VW:0]           delta, delta_neg;
	logic                         up, at_target;
	logic [VW-1:0]                mag, mag_sh, step, disp_step;
	logic [mnb_pkg::SHIFT_W-1:0]  sh;
	logic signed [VW-1:0]         disp_next;

	assign delta     = (VW + 1)'(target_q) - (VW + 1)'(display_q);
	assign delta_neg = -delta;
	assign up        = delta > 0;
	assign at_target = delta == 0;
	assign mag       = up ? delta[VW-1:0] : delta_neg[VW-1:0];
	assign sh        = up ? cfg.attack_shift : cfg.decay_shift;
	assign mag_sh    = mag >> sh;
	// zero shift jumps, otherwise the step is never below 1
	assign step      = (sh == '0) ? mag : ((mag_sh == '0) ? VW'(1) : mag_sh);
	assign disp_step = up ? (display_q + step) : (display_q - step);

	always_comb begin
		if (is_tick) begin
			disp_next = at_target ? display_q : disp_step;
		end else begin
			disp_next = jump ? tgt_new : display_q;
		end
	end

	// ---------------- angle operands, taken before stepping ----------------
	logic signed [SW-1:0] rel, rel_neg;
	logic [SW-1:0]        rel_mag;
	logic [DIVW-1:0]      rel_ext, pct_num;
	logic signed [FW:0]   span, span_neg, dang, dang_neg;
	logic [FW-1:0]        span_mag, dang_mag;

	assign rel      = cur_x - min_x;
	assign rel_neg  = -rel;
	assign rel_mag  = rel[SW-1] ? rel_neg : rel;
	assign rel_ext  = DIVW'(rel_mag);
	// times 100 as shifts and adds
	assign pct_num  = (rel_ext << 6) + (rel_ext << 5) + (rel_ext << 2);

	assign span       = (FW + 1)'(cfg.max_value) - (FW + 1)'(cfg.min_value);
	assign span_neg   = -span;
	assign span_mag   = span[FW] ? span_neg[FW-1:0] : span[FW-1:0];
	assign span_empty = (span == '0);

	assign dang     = (FW + 1)'(cfg.angle_end) - (FW + 1)'(cfg.angle_start);
	assign dang_neg = -dang;
	assign dang_mag = dang[FW] ? dang_neg[FW-1:0] : dang[FW-1:0];

	// operands held across the divider passes
	logic          pct_neg_q;
	logic          dang_neg_q;
	logic [FW-1:0] dang_mag_q;
	logic [PW-1:0] pct_q;
	logic [PW-1:0] pct_sat;

	// Past 2^24-1 the angle saturates whatever the span, so the
	// percentage is held there; a zero angle span still gives start.
	assign pct_sat = (|div_quotient[DIVW-1:PW]) ? '1 : div_quotient[PW-1:0];

	// ---------------- final angle: signed offset, add, saturate ----------------
	logic signed [AW-1:0] term_pos, term, ang_sum;
	logic signed [FW-1:0] ang_sat;

	assign term_pos = AW'(div_quotient);
	assign term     = (pct_neg_q ^ dang_neg_q) ? -term_pos : term_pos;
	assign ang_sum  = AW'(cfg.angle_start) + term;

	always_comb begin
		if (ang_sum > ANG_HI) begin
			ang_sat = {1'b0, {(FW - 1){1'b1}}};
		end else if (ang_sum < ANG_LO) begin
			ang_sat = {1'b1, {(FW - 1){1'b0}}};
		end else begin
			ang_sat = ang_sum[FW-1:0];
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mnb_pkg::ST_IDLE: begin
				if (accept && is_tick && !span_empty) begin
					state_d = mnb_pkg::ST_PCT;
				end
			end
			mnb_pkg::ST_PCT: begin
				if (div_done) begin
					state_d = mnb_pkg::ST_MUL;
				end
			end
			mnb_pkg::ST_MUL: begin
				state_d = mnb_pkg::ST_ANG;
			end
			mnb_pkg::ST_ANG: begin
				if (div_done) begin
					state_d = mnb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mnb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready   = (state_q == mnb_pkg::ST_IDLE) && (!res_valid_q || result_ready);
		quick_done   = accept && (!is_tick || span_empty);
		load_pct     = (state_q == mnb_pkg::ST_PCT) && div_done;
		finish       = (state_q == mnb_pkg::ST_ANG) && div_done;
		div_start    = (accept && is_tick && !span_empty) || (state_q == mnb_pkg::ST_MUL);
		// idle: percentage pass; otherwise the product goes into the divider
		if (state_q == mnb_pkg::ST_IDLE) begin
			div_dividend = pct_num;
			div_divisor  = span_mag;
		end else begin
			div_dividend = DIVW'(dang_mag_q) * DIVW'(pct_q);
			div_divisor  = mnb_pkg::DIVISOR_W'(mnb_pkg::PCT_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mnb_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			target_q    <= '0;
			display_q   <= '0;
		end else begin
			state_q <= state_d;
			if (quick_done || finish) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				display_q <= disp_next;
				if (!is_tick) begin
					target_q <= tgt_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.shown_value <= FW'(disp_next);
			res_q.settled     <= is_tick && at_target;
			res_q.needle_angle <= is_tick ? cfg.angle_start : '0;
			pct_neg_q  <= rel[SW-1] ^ span[FW];
			dang_neg_q <= dang[FW];
			dang_mag_q <= dang_mag;
		end
		if (load_pct) begin
			pct_q <= pct_sat;
		end
		if (finish) begin
			res_q.needle_angle <= ang_sat;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// ---------------- assertions ----------------
	// no result is offered while a tick is still being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mnb_pkg::ST_IDLE) |-> !result_valid)
		else $error("result offered while sequencer busy");

	// the divider only reports back during one of its two passes
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == mnb_pkg::ST_PCT) || (state_q == mnb_pkg::ST_ANG)))
		else $error("divider done outside a divide pass");

	// a tick over a non-empty range starts the percentage pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_tick && !span_empty) |=> (state_q == mnb_pkg::ST_PCT) && !result_valid)
		else $error("tick did not start the percentage pass");

	// a set, or a tick over an empty range, shows its result right away
	assert property (@(posedge clk) disable iff (!arst_n)
		quick_done |=> result_valid && (state_q == mnb_pkg::ST_IDLE))
		else $error("one-cycle transaction gave no result");

endmodule

/* sim/meter_needle_ballistics_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_needle_ballistics_tb: self-checking regression for the needle block
// A directed walk covers the reset state, range clamps, empty and inverted
// ranges, large shifts and angle saturation. Random phases then reprogram the
// meter and stream sets and ticks under random idling on both channels.
// Every result is checked against a cycle-free predictor of the needle.
// ----------------------------------------------------------------------------
module meter_needle_ballistics_tb;

	// Spare register indexes: writes to them must leave the meter untouched.
	localparam logic [mnb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [mnb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// The drain outlasts a tick with margin.
	localparam int DRAIN_CYCLES = 100;
	// Longest quiet stretch in a good run: a tick, a result stall, a burst
	// of register writes and the idle gap before the next item. Allow far
	// more.
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1330;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	mnb_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	mnb_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [mnb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mnb_pkg::FIELD_W-1:0] cfg_data = '0;

	meter_needle_ballistics u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: a private copy of the register file and needle state,
	// kept in step with the block at every accepted write and item.
	// ------------------------------------------------------------------
	logic signed [mnb_pkg::FIELD_W-1:0] lo_lim = mnb_pkg::MIN_RST;
	logic signed [mnb_pkg::FIELD_W-1:0] hi_lim = mnb_pkg::MAX_RST;
	logic [mnb_pkg::SHIFT_W-1:0] rise_sh = '0;
	logic [mnb_pkg::SHIFT_W-1:0] fall_sh = '0;
	logic signed [mnb_pkg::FIELD_W-1:0] ang_lo = mnb_pkg::ANGLE_BEG_RST;
	logic signed [mnb_pkg::FIELD_W-1:0] ang_hi = mnb_pkg::ANGLE_END_RST;
	logic signed [mnb_pkg::FIELD_W-1:0] goal = '0;   // clamped target
	logic signed [mnb_pkg::FIELD_W-1:0] shown = '0;  // displayed value

	function automatic void apply_register(logic [mnb_pkg::CFG_IDX_W-1:0] idx,
			logic [mnb_pkg::FIELD_W-1:0] d);
		case (idx)
			mnb_pkg::CFG_MIN_VALUE: lo_lim = d;
			mnb_pkg::CFG_MAX_VALUE: hi_lim = d;
			mnb_pkg::CFG_ATTACK_SHIFT: rise_sh = d[mnb_pkg::SHIFT_W-1:0];
			mnb_pkg::CFG_DECAY_SHIFT: fall_sh = d[mnb_pkg::SHIFT_W-1:0];
			mnb_pkg::CFG_ANGLE_START: ang_lo = d;
			mnb_pkg::CFG_ANGLE_END: ang_hi = d;
			default: ;  // spare indexes are dropped
		endcase
	endfunction

	// Handles one item and returns the reading the block must produce.
	function automatic mnb_pkg::result_t step_needle(mnb_pkg::item_t it);
		mnb_pkg::result_t r;
		longint v, cur, tgt, span, pct, ang, d;
		r = '0;
		v = longint'($signed(it.value));
		if (it.op == mnb_pkg::OP_SET) begin
			// Below-min is tested first, so an inverted range always clamps.
			if (v < longint'(lo_lim)) begin
				goal = lo_lim;
			end else if (v > longint'(hi_lim)) begin
				goal = hi_lim;
			end else begin
				goal = it.value;
				if ((longint'(shown) < v && rise_sh == 0) ||
						(longint'(shown) > v && fall_sh == 0)) begin
					shown = goal;
				end
			end
		end else begin
			cur = longint'(shown);
			tgt = longint'(goal);
			span = longint'(hi_lim) - longint'(lo_lim);
			if (span == 0) begin
				ang = longint'(ang_lo);
			end else begin
				// Signed division truncates toward zero, as the block does.
				pct = ((cur - longint'(lo_lim)) * mnb_pkg::PCT_SCALE) / span;
				ang = longint'(ang_lo) +
					((longint'(ang_hi) - longint'(ang_lo)) * pct) / mnb_pkg::PCT_SCALE;
				if (ang > 32767) ang = 32767;
				if (ang < -32768) ang = -32768;
			end
			r.needle_angle = ang[mnb_pkg::FIELD_W-1:0];
			if (cur == tgt) begin
				r.settled = 1'b1;
			end else if (cur < tgt) begin
				if (rise_sh == 0) begin
					cur = tgt;
				end else begin
					d = (tgt - cur) >> rise_sh;
					if (d == 0) d = 1;
					cur = cur + d;
				end
			end else begin
				if (fall_sh == 0) begin
					cur = tgt;
				end else begin
					d = (cur - tgt) >> fall_sh;
					if (d == 0) d = 1;
					cur = cur - d;
				end
			end
			shown = cur[mnb_pkg::FIELD_W-1:0];
		end
		r.shown_value = shown;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	typedef struct packed {
		logic known;
		mnb_pkg::result_t want;
	} fixed_answer_t;

	fixed_answer_t fixed_answers[$];            // one per item, in send order
	mnb_pkg::result_t expected_readings[$];     // readings still owed by the block
	int items_sent = 0;
	int results_seen = 0;
	int faults = 0;

	always @(posedge clk) begin : scoreboard
		mnb_pkg::result_t want;
		fixed_answer_t fa;
		if (arst_n) begin
			// Check the outgoing transaction first: it belongs to an older item
			// than one accepted on the same edge.
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					faults++;
					if (faults <= MAX_REPORTS)
						$display("unexpected result: shown=%0d angle=%0d settled=%0b",
							$signed(result.shown_value), $signed(result.needle_angle),
							result.settled);
				end else begin
					want = expected_readings.pop_front();
					results_seen++;
					if (want.shown_value !== result.shown_value ||
							want.needle_angle !== result.needle_angle ||
							want.settled !== result.settled) begin
						faults++;
						if (faults <= MAX_REPORTS)
							$display({"mismatch on result %0d: ",
								"expected shown=%0d angle=%0d settled=%0b, ",
								"got shown=%0d angle=%0d settled=%0b"},
								results_seen,
								$signed(want.shown_value), $signed(want.needle_angle),
								want.settled,
								$signed(result.shown_value), $signed(result.needle_angle),
								result.settled);
					end
				end
			end
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			if (item_valid && item_ready) begin
				// The predictor always runs so its state stays in step; a typed
				// answer from the walk table overrides its reading.
				want = step_needle(item);
				if (fixed_answers.size() != 0) begin
					fa = fixed_answers.pop_front();
					if (fa.known)
						want = fa.want;
				end
				expected_readings.push_back(want);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when no transaction moves for too long.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("meter_needle_ballistics regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure, dropped entirely in busy phases.
	// ------------------------------------------------------------------
	logic no_idle = 1'b0;

	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Presents one item after a random gap and holds it until accepted.
	task automatic send_item(mnb_pkg::item_t it, logic known, mnb_pkg::result_t want);
		int gap;
		fixed_answer_t fa;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fa.known = known;
		fa.want = want;
		fixed_answers.push_back(fa);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// Drops valid and waits until every reading owed has come back;
	// each item yields exactly one result, so the block is then idle.
	task automatic settle();
		item_valid <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
	endtask

	task automatic write_reg(logic [mnb_pkg::CFG_IDX_W-1:0] idx,
			logic [mnb_pkg::FIELD_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [mnb_pkg::SHIFT_W-1:0] pick_shift();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return '0;
		if (r < 8) return mnb_pkg::SHIFT_W'($urandom_range(1, 8));
		if (r < 9) return mnb_pkg::SHIFT_W'($urandom_range(9, 16));
		return mnb_pkg::SHIFT_W'($urandom_range(17, 31));
	endfunction

	function automatic logic [mnb_pkg::FIELD_W-1:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'd0;
			3: return 16'd180;
			default: return mnb_pkg::FIELD_W'($urandom);
		endcase
	endfunction

	// New range, shifts and angles; extremes, empty and inverted ranges
	// show up now and then.
	task automatic load_settings();
		int lo, hi, t;
		logic [mnb_pkg::FIELD_W-1:0] d;
		lo = int'($urandom_range(0, 65535)) - 32768;
		hi = int'($urandom_range(0, 65535)) - 32768;
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		case ($urandom_range(0, 9))
			0: begin
				lo = -32768;
				hi = 32767;
			end
			1: hi = lo;
			2: begin
				t = lo;
				lo = hi;
				hi = t;
			end
			3, 4, 5, 6: begin
				hi = lo + int'($urandom_range(1, 200));
				if (hi > 32767) hi = 32767;
			end
			default: ;
		endcase
		write_reg(mnb_pkg::CFG_MIN_VALUE, mnb_pkg::FIELD_W'(lo));
		write_reg(mnb_pkg::CFG_MAX_VALUE, mnb_pkg::FIELD_W'(hi));
		// Junk in the upper data bits must be ignored by the shift registers.
		d = mnb_pkg::FIELD_W'($urandom);
		d[mnb_pkg::SHIFT_W-1:0] = pick_shift();
		write_reg(mnb_pkg::CFG_ATTACK_SHIFT, d);
		d = mnb_pkg::FIELD_W'($urandom);
		d[mnb_pkg::SHIFT_W-1:0] = pick_shift();
		write_reg(mnb_pkg::CFG_DECAY_SHIFT, d);
		write_reg(mnb_pkg::CFG_ANGLE_START, pick_angle());
		write_reg(mnb_pkg::CFG_ANGLE_END, pick_angle());
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				mnb_pkg::FIELD_W'($urandom));
	endtask

	// Set values lean on the current range edges and their neighbors.
	function automatic logic signed [mnb_pkg::FIELD_W-1:0] pick_target();
		case ($urandom_range(0, 9))
			0: return mnb_pkg::FIELD_W'($urandom);
			1: return lo_lim;
			2: return hi_lim;
			3: return lo_lim - 16'sd1;
			4: return hi_lim + 16'sd1;
			5: return 16'sh8000;
			6: return 16'sh7FFF;
			default: begin
				if (lo_lim <= hi_lim)
					return mnb_pkg::FIELD_W'(int'(lo_lim) +
						int'($urandom_range(0, int'(hi_lim) - int'(lo_lim))));
				return mnb_pkg::FIELD_W'($urandom);
			end
		endcase
	endfunction

	function automatic mnb_pkg::item_t pick_item();
		mnb_pkg::item_t it;
		it.value = mnb_pkg::FIELD_W'($urandom);
		if ($urandom_range(0, 99) < 30) begin
			it.op = mnb_pkg::OP_SET;
			it.value = pick_target();
		end else begin
			it.op = mnb_pkg::OP_TICK;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Directed walk table
	// ------------------------------------------------------------------
	typedef struct packed {
		logic is_write;
		logic [mnb_pkg::CFG_IDX_W-1:0] idx;
		logic [mnb_pkg::FIELD_W-1:0] data;
		mnb_pkg::item_t stim;
		logic known;
		mnb_pkg::result_t want;
	} walk_row_t;

	function automatic walk_row_t cfg_row(logic [mnb_pkg::CFG_IDX_W-1:0] idx,
			logic [mnb_pkg::FIELD_W-1:0] d);
		walk_row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.idx = idx;
		r.data = d;
		return r;
	endfunction

	function automatic walk_row_t item_row(mnb_pkg::op_t op,
			logic signed [mnb_pkg::FIELD_W-1:0] v);
		walk_row_t r;
		r = '0;
		r.stim.op = op;
		r.stim.value = v;
		return r;
	endfunction

	function automatic walk_row_t typed_row(mnb_pkg::op_t op,
			logic signed [mnb_pkg::FIELD_W-1:0] v,
			logic signed [mnb_pkg::FIELD_W-1:0] shown_v,
			logic signed [mnb_pkg::FIELD_W-1:0] ang,
			logic st);
		walk_row_t r;
		r = item_row(op, v);
		r.known = 1'b1;
		r.want.shown_value = shown_v;
		r.want.needle_angle = ang;
		r.want.settled = st;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		walk_row_t walk[$];
		int n;
		int random_items;

		// Reset defaults: range 0..100, both shifts jump, angles 0..180.
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sd0, 16'sd0, 16'sd0, 1'b1));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd100, 16'sd100, 16'sd0, 1'b0));
		// the value field of a tick is don't-care
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sh7FFF, 16'sd100, 16'sd180, 1'b1));
		// out-of-range sets clamp and never jump the needle
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd200, 16'sd100, 16'sd0, 1'b0));
		walk.push_back(typed_row(mnb_pkg::OP_SET, -16'sd5, 16'sd100, 16'sd0, 1'b0));
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sd0, 16'sd0, 16'sd180, 1'b0));
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sd0, 16'sd0, 16'sd0, 1'b1));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd50, 16'sd50, 16'sd0, 1'b0));
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sd0, 16'sd50, 16'sd90, 1'b1));
		// Full 16-bit range and angles, slow attack, slowest decay.
		walk.push_back(cfg_row(mnb_pkg::CFG_MIN_VALUE, 16'h8000));
		walk.push_back(cfg_row(mnb_pkg::CFG_MAX_VALUE, 16'h7FFF));
		walk.push_back(cfg_row(mnb_pkg::CFG_ATTACK_SHIFT, 16'd1));
		walk.push_back(cfg_row(mnb_pkg::CFG_DECAY_SHIFT, 16'd31));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_START, 16'h8000));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'h7FFF));
		walk.push_back(cfg_row(CFG_SPARE_LO, 16'hFFFF));
		walk.push_back(cfg_row(CFG_SPARE_HI, 16'h5555));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sh7FFF, 16'sd50, 16'sd0, 1'b0));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		walk.push_back(item_row(mnb_pkg::OP_SET, 16'sh8000));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		// Upper data bits set: only the low five reach the shifts (31, 16).
		walk.push_back(cfg_row(mnb_pkg::CFG_ATTACK_SHIFT, 16'hFFFF));
		walk.push_back(cfg_row(mnb_pkg::CFG_DECAY_SHIFT, 16'hFFF0));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		walk.push_back(item_row(mnb_pkg::OP_SET, 16'sh7FFF));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		// Empty range: the needle sits at the start angle.
		walk.push_back(cfg_row(mnb_pkg::CFG_MIN_VALUE, 16'd7));
		walk.push_back(cfg_row(mnb_pkg::CFG_MAX_VALUE, 16'd7));
		walk.push_back(cfg_row(mnb_pkg::CFG_ATTACK_SHIFT, 16'd0));
		walk.push_back(cfg_row(mnb_pkg::CFG_DECAY_SHIFT, 16'd0));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_START, -16'sd300));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'sd300));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd7, 16'sd7, 16'sd0, 1'b0));
		walk.push_back(typed_row(mnb_pkg::OP_TICK, 16'sd0, 16'sd7, -16'sd300, 1'b1));
		// Inverted range: every set clamps to min or max.
		walk.push_back(cfg_row(mnb_pkg::CFG_MIN_VALUE, 16'sd100));
		walk.push_back(cfg_row(mnb_pkg::CFG_MAX_VALUE, -16'sd100));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_START, 16'h8000));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'h7FFF));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd0, 16'sd7, 16'sd0, 1'b0));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		walk.push_back(item_row(mnb_pkg::OP_SET, 16'sd500));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		// Park the needle far outside a tiny range to drive the angle
		// into both saturation limits.
		walk.push_back(cfg_row(mnb_pkg::CFG_MIN_VALUE, 16'h8000));
		walk.push_back(cfg_row(mnb_pkg::CFG_MAX_VALUE, 16'h7FFF));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_START, 16'd0));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'd0));
		walk.push_back(typed_row(mnb_pkg::OP_SET, 16'sd30000, 16'sd30000, 16'sd0, 1'b0));
		walk.push_back(cfg_row(mnb_pkg::CFG_MIN_VALUE, 16'd0));
		walk.push_back(cfg_row(mnb_pkg::CFG_MAX_VALUE, 16'd1));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'h7FFF));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));
		walk.push_back(cfg_row(mnb_pkg::CFG_ANGLE_END, 16'h8000));
		walk.push_back(item_row(mnb_pkg::OP_TICK, 16'sd0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (walk[i]) begin
			if (walk[i].is_write) begin
				// registers only change while nothing is in flight
				settle();
				write_reg(walk[i].idx, walk[i].data);
			end else begin
				send_item(walk[i].stim, walk[i].known, walk[i].want);
			end
		end

		// Random phases: fresh settings, then a burst of sets and ticks.
		// About one phase in four runs without any idling on either side.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			no_idle = ($urandom_range(0, 3) == 0);
			load_settings();
			n = $urandom_range(20, 80);
			repeat (n) send_item(pick_item(), 1'b0, '0);
			random_items += n;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0 && expected_readings.size() == 0)
			$display("meter_needle_ballistics regression: pass");
		else
			$display("meter_needle_ballistics regression: fail");
		$finish;
	end

endmodule
